[hw/rtl/omc_pkg.sv]
// shared types and constants for the multimode output controller
// transaction payloads, configuration register map, mode codes
// no dependencies
package omc_pkg;

	localparam int DATA_W   = 32;
	localparam int OUT_BITS = 12;
	localparam int DUTY_W   = OUT_BITS;
	localparam int DRIVE_W  = 12;
	localparam int IDX_W    = 3;

	typedef enum logic [1:0] {
		MODE_MANUAL = 2'd0,
		MODE_TIMER  = 2'd1,
		MODE_PID    = 2'd2,
		MODE_ONOFF  = 2'd3
	} mode_t;

	typedef enum logic [IDX_W-1:0] {
		REG_MODE       = 3'd0,
		REG_DRIVE      = 3'd1,
		REG_PARAM_LOW  = 3'd2,
		REG_PARAM_HIGH = 3'd3,
		REG_SETPOINT   = 3'd4,
		REG_GAIN_P     = 3'd5,
		REG_GAIN_I     = 3'd6,
		REG_GAIN_D     = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic                     restart;
		logic signed [DATA_W-1:0] measured;
	} in_item_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic              phase_on;
	} out_item_t;

	typedef struct packed {
		mode_t                    mode;
		logic [DRIVE_W-1:0]       drive_level;
		logic signed [DATA_W-1:0] mode_param_low;
		logic signed [DATA_W-1:0] mode_param_high;
		logic signed [DATA_W-1:0] setpoint;
		logic signed [DATA_W-1:0] gain_p;
		logic signed [DATA_W-1:0] gain_i;
		logic signed [DATA_W-1:0] gain_d;
	} cfg_t;

	// per-transaction update strobes for the state holding units
	typedef struct packed {
		logic step;
		logic restart;
	} step_ctl_t;

endpackage

[hw/rtl/omc_cfg.sv]
// configuration register file, write-only port
// depends on omc_pkg
module omc_cfg
	import omc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_wdata,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MODE:       cfg_q.mode <= mode_t'(cfg_wdata[1:0]);
				REG_DRIVE:      cfg_q.drive_level <= cfg_wdata[DRIVE_W-1:0];
				REG_PARAM_LOW:  cfg_q.mode_param_low <= $signed(cfg_wdata);
				REG_PARAM_HIGH: cfg_q.mode_param_high <= $signed(cfg_wdata);
				REG_SETPOINT:   cfg_q.setpoint <= $signed(cfg_wdata);
				REG_GAIN_P:     cfg_q.gain_p <= $signed(cfg_wdata);
				REG_GAIN_I:     cfg_q.gain_i <= $signed(cfg_wdata);
				REG_GAIN_D:     cfg_q.gain_d <= $signed(cfg_wdata);
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hw/rtl/omc_timer.sv]
// on/off interval timer: tick counter, phase flag and current phase limit
// depends on omc_pkg
module omc_timer
	import omc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  step_ctl_t                ctl,
	input  logic signed [DATA_W-1:0] on_ticks,
	input  logic signed [DATA_W-1:0] off_ticks,
	output logic                     phase_nxt
);

	logic [DATA_W-1:0]        tick_q;
	logic                     phase_q;
	logic signed [DATA_W-1:0] limit_q;

	logic [DATA_W-1:0]        tick_inc;
	logic                     toggle;
	logic                     phase_t;

	assign tick_inc = tick_q + DATA_W'(1);
	// counter wraps, compare is signed so a negative limit flips every tick
	assign toggle   = $signed(tick_inc) > limit_q;
	assign phase_t  = phase_q ^ toggle;

	always_comb begin
		if (ctl.restart) begin
			phase_nxt = 1'b1;
		end else if (ctl.step) begin
			phase_nxt = phase_t;
		end else begin
			phase_nxt = phase_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			phase_q <= 1'b1;
			limit_q <= '0;
		end else if (ctl.restart) begin
			tick_q  <= '0;
			phase_q <= 1'b1;
			limit_q <= on_ticks;
		end else if (ctl.step) begin
			tick_q  <= toggle ? '0 : tick_inc;
			phase_q <= phase_t;
			limit_q <= phase_t ? on_ticks : off_ticks;
		end
	end

endmodule

[hw/rtl/omc_pid.sv]
// pid unit: shift filter, p/i/d products, clamped integral and output
// depends on omc_pkg
module omc_pid
	import omc_pkg::*;
#(
	parameter int FILTER_SHIFT = 2,
	parameter int FRAC_BITS    = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  step_ctl_t                ctl,
	input  logic signed [DATA_W-1:0] measured,
	input  logic signed [DATA_W-1:0] setpoint,
	input  logic signed [DATA_W-1:0] gain_p,
	input  logic signed [DATA_W-1:0] gain_i,
	input  logic signed [DATA_W-1:0] gain_d,
	output logic [OUT_BITS-1:0]      duty
);

	localparam int QW  = OUT_BITS + FRAC_BITS;
	localparam int EW  = DATA_W + 1;
	localparam int DW  = DATA_W + 2;
	localparam int PEW = DATA_W + EW;
	localparam int PDW = DATA_W + DW;
	localparam int SW  = PDW + 2;
	localparam logic [QW-1:0] TOP = {{OUT_BITS{1'b1}}, {FRAC_BITS{1'b0}}};

	logic signed [DATA_W-1:0] filt_q;
	logic [QW-1:0]            acc_q;
	logic signed [EW-1:0]     prev_q;

	logic signed [EW-1:0]     diff;
	logic signed [EW-1:0]     filt_sum;
	logic signed [DATA_W-1:0] filt_new;
	logic signed [EW-1:0]     err;
	logic signed [DW-1:0]     derr;
	logic signed [PEW-1:0]    prod_p;
	logic signed [PEW-1:0]    prod_i;
	logic signed [PDW-1:0]    prod_d;
	logic signed [SW-1:0]     acc_x;
	logic [QW-1:0]            acc_new;
	logic [QW-1:0]            total;

	function automatic logic [QW-1:0] clamp_q(input logic signed [SW-1:0] v);
		logic [QW-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > $signed({{(SW-QW){1'b0}}, TOP})) begin
			r = TOP;
		end else begin
			r = v[QW-1:0];
		end
		return r;
	endfunction

	// filtered moves toward the sample, so the sum always fits 32 bits
	assign diff     = EW'(measured) - EW'(filt_q);
	assign filt_sum = EW'(filt_q) + (diff >>> FILTER_SHIFT);
	assign filt_new = filt_sum[DATA_W-1:0];
	assign err      = EW'(setpoint) - EW'(filt_new);
	assign derr     = DW'(err) - DW'(prev_q);

	assign prod_p = PEW'(gain_p) * PEW'(err);
	assign prod_i = PEW'(gain_i) * PEW'(err);
	assign prod_d = PDW'(gain_d) * PDW'(derr);

	assign acc_x   = $signed({{(SW-QW){1'b0}}, acc_q});
	assign acc_new = clamp_q(acc_x + SW'(prod_i >>> FRAC_BITS));
	assign total   = clamp_q($signed({{(SW-QW){1'b0}}, acc_new})
		+ SW'(prod_p >>> FRAC_BITS) + SW'(prod_d >>> FRAC_BITS));
	assign duty    = total[QW-1:FRAC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q <= '0;
			acc_q  <= '0;
			prev_q <= '0;
		end else if (ctl.restart) begin
			filt_q <= measured;
			acc_q  <= '0;
			prev_q <= '0;
		end else if (ctl.step) begin
			filt_q <= filt_new;
			acc_q  <= acc_new;
			prev_q <= err;
		end
	end

endmodule

[hw/rtl/multimode_output_controller_top.sv]
// Multimode output controller top level: input register, mode select, result register.
// Throughput: one transaction per cycle unless out_ready stalls the result register;
// the filter, three products and the clamped integral update form one combinational
// pass that feeds state back.
// Reset: arst_n clears configuration, timer and pid state at once (phase starts on).
// depends on omc_pkg, omc_cfg, omc_timer, omc_pid
module multimode_output_controller_top
	import omc_pkg::*;
#(
	parameter int FILTER_SHIFT = 2,
	parameter int FRAC_BITS    = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_data,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0] cfg_wdata
);

	localparam int XW = OUT_BITS + DUTY_W;

	cfg_t                cfg;
	logic                valid_s1;
	in_item_t            item_s1;
	logic                adv;
	logic                out_valid_q;
	out_item_t           out_data_q;
	logic [OUT_BITS-1:0] duty_hold_q;
	logic [OUT_BITS-1:0] duty_nxt;
	logic [OUT_BITS-1:0] drive_m;
	logic [OUT_BITS-1:0] pid_duty;
	logic [XW-1:0]       drive_x;
	logic [XW-1:0]       duty_x;
	logic [XW-1:0]       hold_x;
	logic                phase_nxt;
	step_ctl_t           timer_ctl;
	step_ctl_t           pid_ctl;
	logic                restart_adv;

	omc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign adv         = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready    = !valid_s1 || adv;
	assign restart_adv = adv && item_s1.restart;

	assign timer_ctl.restart = restart_adv;
	assign timer_ctl.step    = adv && !item_s1.restart && (cfg.mode == MODE_TIMER);
	assign pid_ctl.restart   = restart_adv;
	assign pid_ctl.step      = adv && !item_s1.restart && (cfg.mode == MODE_PID);

	omc_timer u_timer (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (timer_ctl),
		.on_ticks  (cfg.mode_param_low),
		.off_ticks (cfg.mode_param_high),
		.phase_nxt (phase_nxt)
	);

	omc_pid #(
		.FILTER_SHIFT (FILTER_SHIFT),
		.FRAC_BITS    (FRAC_BITS)
	) u_pid (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (pid_ctl),
		.measured (item_s1.measured),
		.setpoint (cfg.setpoint),
		.gain_p   (cfg.gain_p),
		.gain_i   (cfg.gain_i),
		.gain_d   (cfg.gain_d),
		.duty     (pid_duty)
	);

	// level masked to the duty range, duty sized to the port
	assign drive_x = {{OUT_BITS{1'b0}}, cfg.drive_level};
	assign drive_m = drive_x[OUT_BITS-1:0];
	assign duty_x  = {{DUTY_W{1'b0}}, duty_nxt};
	assign hold_x  = {{DUTY_W{1'b0}}, duty_hold_q};

	always_comb begin
		duty_nxt = duty_hold_q;
		if (!item_s1.restart) begin
			unique case (cfg.mode)
				MODE_MANUAL: duty_nxt = drive_m;
				MODE_TIMER:  duty_nxt = phase_nxt ? drive_m : '0;
				MODE_PID:    duty_nxt = pid_duty;
				MODE_ONOFF: begin
					// high test wins when both thresholds are crossed
					if ($signed(item_s1.measured) > $signed(cfg.mode_param_high)) begin
						duty_nxt = '0;
					end else if ($signed(item_s1.measured)
						< $signed(cfg.mode_param_low)) begin
						duty_nxt = drive_m;
					end
				end
				default: duty_nxt = duty_hold_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			duty_hold_q <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
				duty_hold_q <= duty_nxt;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
		if (adv) begin
			out_data_q.duty     <= duty_x[DUTY_W-1:0];
			out_data_q.phase_on <= phase_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// a stalled input stage keeps its transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(item_s1))
		else $error("input stage lost or changed a stalled transaction");

	// every step produces a result in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid)
		else $error("result missing after a step");

	// restart holds the duty and forces the on phase
	assert property (@(posedge clk) disable iff (!arst_n)
		restart_adv |=> out_data.phase_on && (out_data.duty == $past(hold_x[DUTY_W-1:0])))
		else $error("restart changed the duty or phase");

	// no new result is loaded while the previous one waits
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !adv)
		else $error("result register overwritten while stalled");

endmodule

[tb/sv/multimode_output_controller_top_tb.sv]
// self-checking testbench for multimode_output_controller_top
// predicts duty and timer phase per control tick and checks every result transaction
// depends on omc_pkg and the controller rtl
module multimode_output_controller_top_tb;
	import omc_pkg::*;

	localparam int FILTER_SHIFT = 2;
	localparam int FRAC_BITS    = 16;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 300;
	localparam int RAND_PHASES  = 30;
	localparam int PHASE_TICKS  = 65;

	typedef logic signed [79:0] wide_t;
	localparam wide_t DUTY_TOP_Q = wide_t'((1 << OUT_BITS) - 1) << FRAC_BITS;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	in_item_t          in_data   = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	out_item_t         out_data;
	logic              cfg_we    = 1'b0;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [DATA_W-1:0] cfg_wdata = '0;

	// stimulus and expected results
	in_item_t  tick_q[$];
	out_item_t duty_due_q[$];

	int unsigned send_idle_pct = 12;
	int unsigned recv_idle_pct = 70;
	bit          hold_go       = 1'b0;
	logic        hold_off      = 1'b0;
	int unsigned cycle_cnt     = 0;
	int unsigned mismatch_count = 0;
	int unsigned accepted_cnt  = 0;
	int unsigned restart_cnt   = 0;
	int unsigned results_cnt   = 0;
	int unsigned settings_cnt  = 0;
	int unsigned mode_settings [4] = '{0, 0, 0, 0};
	logic signed [31:0] center_pv = '0;

	// controller copy: configuration and state
	cfg_t               ctl_cfg       = '0;
	logic [DUTY_W-1:0]  held_duty     = '0;
	logic [31:0]        ticks         = '0;
	logic               on_phase      = 1'b1;
	logic signed [31:0] phase_limit_q = '0;
	logic signed [31:0] filt_pv       = '0;
	wide_t              integ_q       = '0;
	wide_t              last_err      = '0;

	multimode_output_controller_top #(
		.FILTER_SHIFT(FILTER_SHIFT),
		.FRAC_BITS   (FRAC_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic wide_t clamp_q(input wide_t v);
		if (v < 0)
			return '0;
		if (v > DUTY_TOP_Q)
			return DUTY_TOP_Q;
		return v;
	endfunction

	// one control tick of the controller
	function automatic out_item_t next_duty(input in_item_t t);
		wide_t     pv, delta, err, derr, p_term, i_term, d_term, total;
		out_item_t r;
		pv = $signed(t.measured);
		if (t.restart) begin
			ticks = '0;
			phase_limit_q = ctl_cfg.mode_param_low;
			on_phase = 1'b1;
			integ_q = '0;
			last_err = '0;
			filt_pv = t.measured;
		end else begin
			case (ctl_cfg.mode)
				MODE_MANUAL: held_duty = ctl_cfg.drive_level;
				MODE_TIMER: begin
					ticks = ticks + 1;
					if ($signed(ticks) > phase_limit_q) begin
						on_phase = ~on_phase;
						ticks = '0;
					end
					if (on_phase) begin
						phase_limit_q = ctl_cfg.mode_param_low;
						held_duty = ctl_cfg.drive_level;
					end else begin
						phase_limit_q = ctl_cfg.mode_param_high;
						held_duty = '0;
					end
				end
				MODE_PID: begin
					delta = (pv - filt_pv) >>> FILTER_SHIFT;
					filt_pv = filt_pv + delta[31:0];
					err = $signed(ctl_cfg.setpoint) - filt_pv;
					derr = err - last_err;
					p_term = ($signed(ctl_cfg.gain_p) * err) >>> FRAC_BITS;
					i_term = ($signed(ctl_cfg.gain_i) * err) >>> FRAC_BITS;
					d_term = ($signed(ctl_cfg.gain_d) * derr) >>> FRAC_BITS;
					integ_q = clamp_q(integ_q + i_term);
					total = clamp_q(integ_q + p_term + d_term);
					last_err = err;
					held_duty = total[FRAC_BITS +: OUT_BITS];
				end
				default: begin
					// low test first, so crossed thresholds end at zero
					if (pv < $signed(ctl_cfg.mode_param_low))
						held_duty = ctl_cfg.drive_level;
					if (pv > $signed(ctl_cfg.mode_param_high))
						held_duty = '0;
				end
			endcase
		end
		r.duty = held_duty;
		r.phase_on = on_phase;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		if (mismatch_count < 40)
			$display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycle_cnt, what, got,
				want);
		mismatch_count++;
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				duty_due_q.push_back(next_duty(in_data));
				accepted_cnt++;
				if (in_data.restart)
					restart_cnt++;
			end
			if (!in_valid || in_ready) begin
				if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= tick_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin : result_check
		out_item_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_cnt++;
				if (duty_due_q.size() == 0) begin
					report_mismatch("result with nothing pending", 32'(out_data), 0);
				end else begin
					want = duty_due_q.pop_front();
					if (out_data.duty !== want.duty)
						report_mismatch("duty", 32'(out_data.duty), 32'(want.duty));
					if (out_data.phase_on !== want.phase_on)
						report_mismatch("phase_on", 32'(out_data.phase_on),
							32'(want.phase_on));
				end
			end
			out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// long receiver stall so the block backs up into its input
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	function automatic logic signed [31:0] near(input logic signed [31:0] c,
			input int unsigned span);
		return c + (int'($urandom_range(2 * span)) - int'(span));
	endfunction

	function automatic cfg_t make_cfg(input mode_t m, input logic [DRIVE_W-1:0] lvl,
			input logic [31:0] lo, input logic [31:0] hi, input logic [31:0] sp,
			input logic [31:0] gp, input logic [31:0] gi, input logic [31:0] gd);
		cfg_t c;
		c.mode = m;
		c.drive_level = lvl;
		c.mode_param_low = lo;
		c.mode_param_high = hi;
		c.setpoint = sp;
		c.gain_p = gp;
		c.gain_i = gi;
		c.gain_d = gd;
		return c;
	endfunction

	function automatic logic [31:0] pick_gain();
		if ($urandom_range(9) < 3)
			return $urandom;
		return near(0, 1 << 20);
	endfunction

	function automatic cfg_t rand_cfg();
		cfg_t c;
		logic signed [31:0] a, b, t;
		c = make_cfg(mode_t'($urandom_range(3)), DRIVE_W'($urandom), 0, 0,
			near(center_pv, 1 << 17), pick_gain(), pick_gain(), pick_gain());
		case ($urandom_range(9))
			0: c.drive_level = '0;
			1: c.drive_level = '1;
			default: ;
		endcase
		if (c.mode == MODE_ONOFF) begin
			a = near(center_pv, 1 << 18);
			b = near(center_pv, 1 << 18);
			// mostly ordered, sometimes crossed
			if (a > b && $urandom_range(9) != 0) begin
				t = a;
				a = b;
				b = t;
			end
		end else if ($urandom_range(6) == 0) begin
			a = $urandom;
			b = $urandom;
		end else begin
			a = int'($urandom_range(14)) - 2;
			b = int'($urandom_range(14)) - 2;
		end
		c.mode_param_low = a;
		c.mode_param_high = b;
		return c;
	endfunction

	function automatic logic [31:0] pick_measured();
		case ($urandom_range(9))
			0: return $urandom;
			1: begin
				case ($urandom_range(3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: return near(center_pv, 1 << 18);
		endcase
	endfunction

	task automatic add_tick(input logic rs, input logic [31:0] m);
		in_item_t t;
		t.restart = rs;
		t.measured = m;
		tick_q.push_back(t);
	endtask

	task automatic wait_quiet();
		while (tick_q.size() != 0 || in_valid || duty_due_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register writes only once everything in flight has come out
	task automatic program_controller(input cfg_t c);
		logic [DATA_W-1:0] vals [8];
		reg_idx_t          r;
		wait_quiet();
		vals[REG_MODE] = DATA_W'(c.mode);
		vals[REG_DRIVE] = DATA_W'(c.drive_level);
		vals[REG_PARAM_LOW] = c.mode_param_low;
		vals[REG_PARAM_HIGH] = c.mode_param_high;
		vals[REG_SETPOINT] = c.setpoint;
		vals[REG_GAIN_P] = c.gain_p;
		vals[REG_GAIN_I] = c.gain_i;
		vals[REG_GAIN_D] = c.gain_d;
		r = REG_MODE;
		repeat (8) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= r;
			cfg_wdata <= vals[r];
			r = r.next();
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		ctl_cfg = c;
		settings_cnt++;
		mode_settings[c.mode]++;
		@(negedge clk);
	endtask

	initial begin
		cfg_t c;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// manual mode with extreme measurements, restart holds the duty
		program_controller(make_cfg(MODE_MANUAL, 12'hFFF, 0, 0, 0, 0, 0, 0));
		add_tick(1'b1, 32'h7FFF_FFFF);
		add_tick(1'b0, 32'h8000_0000);
		add_tick(1'b0, 32'h0000_0000);
		add_tick(1'b0, 32'hFFFF_FFFF);

		// timer: three ticks on, two off
		program_controller(make_cfg(MODE_TIMER, 12'hA5A, 2, 1, 0, 0, 0, 0));
		add_tick(1'b1, 32'h0);
		repeat (6) add_tick(1'b0, 32'h1234_5678);

		// negative limits toggle every tick
		program_controller(make_cfg(MODE_TIMER, 12'h001, -1, -5, 0, 0, 0, 0));
		add_tick(1'b1, 32'h0);
		repeat (3) add_tick(1'b0, 32'h0);

		// hysteresis: below, between, above, between
		program_controller(make_cfg(MODE_ONOFF, 12'hFFF, -32'sh1_0000, 32'sh1_0000, 0, 0, 0,
			0));
		add_tick(1'b0, -32'sh2_0000);
		add_tick(1'b0, 32'h0);
		add_tick(1'b0, 32'h2_0000);
		add_tick(1'b0, 32'h0);

		// crossed thresholds give zero
		program_controller(make_cfg(MODE_ONOFF, 12'h7FF, 32'sh100, -32'sh100, 0, 0, 0, 0));
		add_tick(1'b0, 32'h0);

		// pid at extreme gains and measurements
		program_controller(make_cfg(MODE_PID, 12'h0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF));
		add_tick(1'b1, 32'h8000_0000);
		add_tick(1'b0, 32'h8000_0000);
		add_tick(1'b0, 32'h7FFF_FFFF);
		add_tick(1'b0, 32'h0);

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case ($urandom_range(9))
				0, 1: center_pv = '0;
				2, 3, 4: center_pv = $urandom;
				default: center_pv = near(0, 1 << 22);
			endcase
			if (ph == 3)
				c = make_cfg(MODE_ONOFF, '1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
					32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
			else if (ph == 4)
				c = make_cfg(MODE_MANUAL, '0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
					32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
			else
				c = rand_cfg();
			program_controller(c);
			if (ph < RAND_PHASES / 3) begin
				send_idle_pct = 12;
				recv_idle_pct = 70;
			end else if (ph < 2 * RAND_PHASES / 3) begin
				send_idle_pct = 70;
				recv_idle_pct = 12;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (ph == RAND_PHASES - 7)
				hold_go = 1'b1;
			repeat (PHASE_TICKS)
				add_tick($urandom_range(24) == 0, pick_measured());
		end

		wait_quiet();
		repeat (8) @(posedge clk);
		$display("%0d tick transactions (%0d restarts) checked, %0d results, %0d settings",
			accepted_cnt, restart_cnt, results_cnt, settings_cnt);
		$display("settings per mode: manual %0d, timer %0d, pid %0d, on-off %0d",
			mode_settings[MODE_MANUAL], mode_settings[MODE_TIMER], mode_settings[MODE_PID],
			mode_settings[MODE_ONOFF]);
		if (mismatch_count == 0 && duty_due_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[multimode_output_controller_top.f]
hw/rtl/omc_pkg.sv
hw/rtl/omc_cfg.sv
hw/rtl/omc_timer.sv
hw/rtl/omc_pid.sv
hw/rtl/multimode_output_controller_top.sv
tb/sv/multimode_output_controller_top_tb.sv
